// File: sv/psncc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psncc_pkg
// Shared constants of the power-spectrum correlation score block.
// ----------------------------------------------------------------------------
package psncc_pkg;

    localparam int P_MAX_BINS  = 256;
    localparam int P_COEF_BITS = 12;

    localparam int               CFG_W   = 9;
    localparam logic [CFG_W-1:0] CFG_RST = 9'd256;

    localparam int SCORE_W = 17;
    localparam int STAT_W  = 2;
    localparam int OUT_DW  = 24;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZDEV  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOBIN = 2'd2;

    localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;

    // (score + 49 * one), gain = 50 * one
    localparam int              F_W     = 22;
    localparam logic [F_W-1:0]  OFFS_Q  = 22'd3211264;
    localparam int              G2_W    = 44;
    localparam logic [G2_W-1:0] GAIN_Q2 = 44'd10737418240000;

    localparam int             SM_W   = 3;
    localparam logic [SM_W-1:0] S_IDLE = 3'd0;
    localparam logic [SM_W-1:0] S_ITEM = 3'd1;
    localparam logic [SM_W-1:0] S_FIN  = 3'd2;
    localparam logic [SM_W-1:0] S_MUL  = 3'd3;
    localparam logic [SM_W-1:0] S_POST = 3'd4;
    localparam logic [SM_W-1:0] S_OUT  = 3'd5;

    localparam int             PC_W    = 4;
    localparam logic [PC_W-1:0] PC_NSQA = 4'd0;
    localparam logic [PC_W-1:0] PC_SA2  = 4'd1;
    localparam logic [PC_W-1:0] PC_NSQB = 4'd2;
    localparam logic [PC_W-1:0] PC_SB2  = 4'd3;
    localparam logic [PC_W-1:0] PC_NX   = 4'd4;
    localparam logic [PC_W-1:0] PC_SAB  = 4'd5;
    localparam logic [PC_W-1:0] PC_CC   = 4'd6;
    localparam logic [PC_W-1:0] PC_CG   = 4'd7;
    localparam logic [PC_W-1:0] PC_VV   = 4'd8;
    localparam logic [PC_W-1:0] PC_F2   = 4'd9;
    localparam logic [PC_W-1:0] PC_LF   = 4'd10;

endpackage

// File: sv/power_spectrum_ncc_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_spectrum_ncc_score
// Pearson correlation score of the power values of two spectra.
// ----------------------------------------------------------------------------
// One MW x MW multiplier (MW = 2*COEF_BITS) does all the multiplications under a
// small sequencer. A bin that counts is accepted, then runs four coefficient
// squares, three power products and one drain; a bin beyond the limit is only
// accepted. The tlast transaction then runs the finish: nine wide products built
// limb by limb on the same multiplier, then a binary search of at most 17 steps
// of two products each. The input is not ready while a bin or the finish is in
// work or a result waits for the output register; one finished score may wait in
// the output register while the next frame streams in.
module power_spectrum_ncc_score
    import psncc_pkg::*;
#(
    parameter int MAX_BINS  = P_MAX_BINS,
    parameter int COEF_BITS = P_COEF_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wen,
    input  logic [CFG_W-1:0]                 i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // re_a, im_a, re_b, im_b
    input  logic [((4*COEF_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // score
    output logic [OUT_DW-1:0]                m_axis_tdata,
    // status
    output logic [STAT_W-1:0]                m_axis_tuser
);

    localparam int CB   = COEF_BITS;
    localparam int MW   = 2 * CB;
    localparam int PW   = 2 * CB;
    localparam int NB   = $clog2(MAX_BINS + 1);
    localparam int SPW  = PW + NB;
    localparam int SQW  = 2 * PW + NB;
    localparam int VW   = 2 * PW + 2 * NB;
    localparam int BW   = 2 * VW + G2_W;
    localparam int NL   = (BW + MW - 1) / MW;
    localparam int AW   = NL * MW;
    localparam int LIW  = $clog2(NL);
    localparam int LCW  = $clog2(NL + 1);
    localparam int CMPW = (NB > CFG_W) ? NB + 1 : CFG_W + 1;

    localparam logic [LCW-1:0] L_N   = LCW'((NB + MW - 1) / MW);
    localparam logic [LCW-1:0] L_SQ  = LCW'((SQW + MW - 1) / MW);
    localparam logic [LCW-1:0] L_SP  = LCW'((SPW + MW - 1) / MW);
    localparam logic [LCW-1:0] L_V   = LCW'((VW + MW - 1) / MW);
    localparam logic [LCW-1:0] L_X2  = LCW'((2 * VW + MW - 1) / MW);
    localparam logic [LCW-1:0] L_G   = LCW'((G2_W + MW - 1) / MW);
    localparam logic [LCW-1:0] L_F   = LCW'((F_W + MW - 1) / MW);

    logic [SM_W-1:0]    r_state;
    logic [PC_W-1:0]    r_pc;
    logic [2:0]         r_k;
    logic [CFG_W-1:0]   r_maxb;
    logic [NB-1:0]      r_cnt;
    logic [SPW-1:0]     r_spa, r_spb;
    logic [SQW-1:0]     r_sqa, r_sqb, r_sx;
    logic [CB-1:0]      r_ma, r_mia, r_mb, r_mib;
    logic               r_last;
    logic [PW-1:0]      r_pa, r_pb;
    logic [2*MW-1:0]    r_prod;
    logic [2:0]         r_ptag;
    logic               r_pv;
    logic [LIW:0]       r_psh;
    logic               r_iss;
    logic [LIW-1:0]     r_i, r_j;
    logic [LCW-1:0]     r_na, r_nb;
    logic [AW-1:0]      r_opa, r_opb, r_acc;
    logic [BW-1:0]      r_x, r_rhs;
    logic [VW-1:0]      r_va, r_vb, r_c;
    logic [2*VW-1:0]    r_lhs;
    logic [G2_W-1:0]    r_f2;
    logic [SCORE_W-1:0] r_lo, r_hi, r_mid;
    logic [SCORE_W-1:0] r_rscore, r_oscore;
    logic [STAT_W-1:0]  r_rstat, r_ostat;
    logic               r_ovalid;

    logic [MW-1:0]      w_ma, w_mb;
    logic [2*MW-1:0]    w_prod;
    logic [AW-1:0]      n_acc;
    logic [BW-1:0]      w_diff;
    logic [CMPW-1:0]    w_lim;
    logic               w_use;
    logic [SCORE_W:0]   w_mid;
    logic [F_W-1:0]     w_f;
    logic [CB-1:0]      w_ra, w_ia, w_rb, w_ib;

    function automatic logic [CB-1:0] mag(input logic [CB-1:0] v);
        mag = v[CB-1] ? (~v + CB'(1)) : v;
    endfunction

    assign w_ra = s_axis_tdata[CB-1:0];
    assign w_ia = s_axis_tdata[2*CB-1:CB];
    assign w_rb = s_axis_tdata[3*CB-1:2*CB];
    assign w_ib = s_axis_tdata[4*CB-1:3*CB];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_DW'(r_oscore);
    assign m_axis_tuser  = r_ostat;

    assign w_lim = (CMPW'(r_maxb) < CMPW'(MAX_BINS)) ? CMPW'(r_maxb) : CMPW'(MAX_BINS);
    assign w_use = CMPW'(r_cnt) < w_lim;

    assign w_mid  = {1'b0, r_lo} + (({1'b0, r_hi} - {1'b0, r_lo} + (SCORE_W+1)'(1)) >> 1);
    assign w_f    = F_W'(w_mid[SCORE_W-1:0]) + OFFS_Q;
    assign w_diff = r_x - r_acc[BW-1:0];

    always_comb begin
        w_ma = r_opa[r_i*MW +: MW];
        w_mb = r_opb[r_j*MW +: MW];
        if (r_state == S_ITEM) begin
            case (r_k)
                3'd0: begin w_ma = MW'(r_ma);  w_mb = MW'(r_ma);  end
                3'd1: begin w_ma = MW'(r_mia); w_mb = MW'(r_mia); end
                3'd2: begin w_ma = MW'(r_mb);  w_mb = MW'(r_mb);  end
                3'd3: begin w_ma = MW'(r_mib); w_mb = MW'(r_mib); end
                3'd4: begin w_ma = r_pa;       w_mb = r_pa;       end
                3'd5: begin w_ma = r_pb;       w_mb = r_pb;       end
                3'd6: begin w_ma = r_pa;       w_mb = r_pb;       end
                default: begin w_ma = '0;      w_mb = '0;         end
            endcase
        end
    end

    assign w_prod = w_ma * w_mb;
    assign n_acc  = r_acc + (AW'(r_prod) << (r_psh * MW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= PC_NSQA;
            r_k      <= '0;
            r_maxb   <= CFG_RST;
            r_cnt    <= '0;
            r_spa    <= '0;
            r_spb    <= '0;
            r_sqa    <= '0;
            r_sqb    <= '0;
            r_sx     <= '0;
            r_pv     <= 1'b0;
            r_iss    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_maxb <= i_cfg_wdata;
            end
            if (r_ovalid && m_axis_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_ma   <= mag(w_ra);
                        r_mia  <= mag(w_ia);
                        r_mb   <= mag(w_rb);
                        r_mib  <= mag(w_ib);
                        r_last <= s_axis_tlast;
                        r_pa   <= '0;
                        r_pb   <= '0;
                        r_k    <= '0;
                        r_pc   <= PC_NSQA;
                        if (w_use) begin
                            r_state <= S_ITEM;
                        end else if (s_axis_tlast) begin
                            r_state <= S_FIN;
                        end
                    end
                end

                S_ITEM: begin
                    r_prod <= w_prod;
                    r_ptag <= r_k;
                    r_pv   <= (r_k != 3'd7);
                    r_k    <= r_k + 3'd1;
                    if (r_pv) begin
                        case (r_ptag)
                            3'd0, 3'd1: r_pa  <= r_pa + PW'(r_prod);
                            3'd2, 3'd3: r_pb  <= r_pb + PW'(r_prod);
                            3'd4:       r_sqa <= r_sqa + SQW'(r_prod);
                            3'd5:       r_sqb <= r_sqb + SQW'(r_prod);
                            3'd6:       r_sx  <= r_sx + SQW'(r_prod);
                            default: ;
                        endcase
                    end
                    if (r_k == 3'd7) begin
                        r_spa   <= r_spa + SPW'(r_pa);
                        r_spb   <= r_spb + SPW'(r_pb);
                        r_cnt   <= r_cnt + NB'(1);
                        r_state <= r_last ? S_FIN : S_IDLE;
                    end
                end

                S_FIN: begin
                    r_acc   <= '0;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_iss   <= 1'b1;
                    r_state <= S_MUL;
                    case (r_pc)
                        PC_NSQA: begin
                            r_opa <= AW'(r_cnt); r_na <= L_N;
                            r_opb <= AW'(r_sqa); r_nb <= L_SQ;
                            if (r_cnt == '0) begin
                                r_iss    <= 1'b0;
                                r_rscore <= '0;
                                r_rstat  <= ST_NOBIN;
                                r_state  <= S_OUT;
                            end
                        end
                        PC_SA2: begin
                            r_opa <= AW'(r_spa); r_na <= L_SP;
                            r_opb <= AW'(r_spa); r_nb <= L_SP;
                        end
                        PC_NSQB: begin
                            r_opa <= AW'(r_cnt); r_na <= L_N;
                            r_opb <= AW'(r_sqb); r_nb <= L_SQ;
                        end
                        PC_SB2: begin
                            r_opa <= AW'(r_spb); r_na <= L_SP;
                            r_opb <= AW'(r_spb); r_nb <= L_SP;
                        end
                        PC_NX: begin
                            r_opa <= AW'(r_cnt); r_na <= L_N;
                            r_opb <= AW'(r_sx);  r_nb <= L_SQ;
                        end
                        PC_SAB: begin
                            r_opa <= AW'(r_spa); r_na <= L_SP;
                            r_opb <= AW'(r_spb); r_nb <= L_SP;
                        end
                        PC_CC: begin
                            r_opa <= AW'(r_c); r_na <= L_V;
                            r_opb <= AW'(r_c); r_nb <= L_V;
                        end
                        PC_CG: begin
                            r_opa <= AW'(r_x);     r_na <= L_X2;
                            r_opb <= AW'(GAIN_Q2); r_nb <= L_G;
                        end
                        PC_VV: begin
                            r_opa <= AW'(r_va); r_na <= L_V;
                            r_opb <= AW'(r_vb); r_nb <= L_V;
                        end
                        PC_F2: begin
                            r_mid <= w_mid[SCORE_W-1:0];
                            r_opa <= AW'(w_f); r_na <= L_F;
                            r_opb <= AW'(w_f); r_nb <= L_F;
                            if (r_lo >= r_hi) begin
                                r_iss    <= 1'b0;
                                r_rscore <= r_lo;
                                r_rstat  <= ST_OK;
                                r_state  <= S_OUT;
                            end
                        end
                        PC_LF: begin
                            r_opa <= AW'(r_lhs); r_na <= L_X2;
                            r_opb <= AW'(r_f2);  r_nb <= L_G;
                        end
                        default: begin
                            r_opa <= '0; r_na <= L_N;
                            r_opb <= '0; r_nb <= L_N;
                        end
                    endcase
                end

                S_MUL: begin
                    if (r_pv) begin
                        r_acc <= n_acc;
                    end
                    if (r_iss) begin
                        r_prod <= w_prod;
                        r_psh  <= (LIW+1)'(r_i) + (LIW+1)'(r_j);
                        r_pv   <= 1'b1;
                        if (LCW'(r_i) == r_na - LCW'(1)) begin
                            r_i <= '0;
                            if (LCW'(r_j) == r_nb - LCW'(1)) begin
                                r_iss <= 1'b0;
                            end else begin
                                r_j <= r_j + LIW'(1);
                            end
                        end else begin
                            r_i <= r_i + LIW'(1);
                        end
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_state <= S_POST;
                        end
                    end
                end

                S_POST: begin
                    r_state <= S_FIN;
                    case (r_pc)
                        PC_NSQA: begin
                            r_x  <= r_acc[BW-1:0];
                            r_pc <= PC_SA2;
                        end
                        PC_SA2: begin
                            r_va <= w_diff[VW-1:0];
                            r_pc <= PC_NSQB;
                        end
                        PC_NSQB: begin
                            r_x  <= r_acc[BW-1:0];
                            r_pc <= PC_SB2;
                        end
                        PC_SB2: begin
                            r_vb <= w_diff[VW-1:0];
                            r_pc <= PC_NX;
                            if (r_va == '0 || w_diff[VW-1:0] == '0) begin
                                r_rscore <= '0;
                                r_rstat  <= ST_ZDEV;
                                r_state  <= S_OUT;
                            end
                        end
                        PC_NX: begin
                            r_x  <= r_acc[BW-1:0];
                            r_pc <= PC_SAB;
                        end
                        PC_SAB: begin
                            r_c  <= w_diff[VW-1:0];
                            r_pc <= PC_CC;
                            if (r_x <= r_acc[BW-1:0]) begin
                                r_rscore <= '0;
                                r_rstat  <= ST_OK;
                                r_state  <= S_OUT;
                            end
                        end
                        PC_CC: begin
                            r_x  <= r_acc[BW-1:0];
                            r_pc <= PC_CG;
                        end
                        PC_CG: begin
                            r_rhs <= r_acc[BW-1:0];
                            r_pc  <= PC_VV;
                        end
                        PC_VV: begin
                            r_lhs <= r_acc[2*VW-1:0];
                            r_lo  <= '0;
                            r_hi  <= SCORE_ONE;
                            r_pc  <= PC_F2;
                        end
                        PC_F2: begin
                            r_f2 <= r_acc[G2_W-1:0];
                            r_pc <= PC_LF;
                        end
                        PC_LF: begin
                            if (r_acc[BW-1:0] <= r_rhs) begin
                                r_lo <= r_mid;
                            end else begin
                                r_hi <= r_mid - SCORE_W'(1);
                            end
                            r_pc <= PC_F2;
                        end
                        default: begin
                            r_pc <= PC_NSQA;
                        end
                    endcase
                end

                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_oscore <= r_rscore;
                        r_ostat  <= r_rstat;
                        r_cnt    <= '0;
                        r_spa    <= '0;
                        r_spb    <= '0;
                        r_sqa    <= '0;
                        r_sqb    <= '0;
                        r_sx     <= '0;
                        r_state  <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_limb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_iss) |-> (LCW'(r_i) < r_na && LCW'(r_j) < r_nb))
        else $error("limb index beyond operand");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_cnt) <= CMPW'(MAX_BINS))
        else $error("bin count above limit");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_oscore <= SCORE_ONE && (r_ostat == ST_OK || r_oscore == '0)))
        else $error("score out of range");

    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_ovalid || m_axis_tready)) |=> (r_cnt == '0))
        else $error("sums not cleared after result");
`endif

endmodule
